// File: rtl/nsr_pkg.sv
// Shared constants, types and helpers for the Newton square root block.
`default_nettype none

package nsr_pkg;

	// Number format and iteration limits
	localparam int FRAC_BITS = 16;
	localparam int MAX_ITER  = 32;
	localparam int GW        = 48;                 // guess width, raw fixed point
	localparam int XW        = 31;                 // radicand width
	localparam int DVW       = XW + 2 * FRAC_BITS; // dividend width, one quotient bit per cycle
	localparam int DCW       = $clog2(DVW);        // divide bit counter width
	localparam int STW       = 7;                  // step count width
	localparam int ROOTW     = 32;                 // Q16.16 root width
	localparam int IN_DW     = 32;                 // s_tdata width
	localparam int OUT_DW    = 40;                 // m_tdata width

	// Convergence test: |y2 - y1| * TOL_RECIP <= y2
	localparam int TOLW  = 17;
	localparam int DIFFW = 32;                     // any larger difference can never pass
	localparam logic [TOLW-1:0] TOL_RECIP = TOLW'(100000);

	localparam logic [GW-1:0] GUESS_ONE = GW'(1) << FRAC_BITS;

	// Divider sequencer states
	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_FIN
	} div_state_t;

	// Main sequencer states
	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_START,
		SQ_WAIT,
		SQ_DIFF,
		SQ_CMP,
		SQ_OUT
	} seq_state_t;

	// Control into the divider
	typedef struct packed {
		logic start;
	} div_ctl_t;

	// Status back from the divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Convert a raw guess to Q16.16, saturating on overflow
	function automatic logic [ROOTW-1:0] to_q16(input logic [GW-1:0] g);
		logic [63:0] v;
		if (FRAC_BITS >= 16) begin
			v = 64'(g) >> (FRAC_BITS - 16);
		end else begin
			v = 64'(g) << (16 - FRAC_BITS);
		end
		if (v[63:ROOTW] != '0) begin
			to_q16 = '1;
		end else begin
			to_q16 = v[ROOTW-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/newton_square_root.sv
// Top level: Newton square root sequencer around a shared bit-serial divider.
//
//  port group | dir | payload                                  | beat taken when
//  s_*        | in  | s_tdata[30:0] radicand                   | s_tvalid && s_tready
//  m_*        | out | m_tdata[31:0] root Q16.16, [38:32] steps | m_tvalid && m_tready
//             |     | m_tuser limit_hit                        |
//
// Each Newton step runs through the divider (load, 63 quotient bits, finish), and every
// step after the first is followed by the convergence test; an item takes n steps,
// with n at most MAX_ITER. A zero radicand skips the divider and goes straight to output.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register, and the next beat is accepted while it waits.
// A stalled m_tready holds the sequencer only when a second result is ready.
// Reset clears the sequencer and the output valid; no memory needs clearing.
`default_nettype none

module newton_square_root import nsr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_DW-1:0]  s_tdata,   // [30:0] radicand, [31] ignored
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_DW-1:0]      m_tdata,   // [31:0] root, [38:32] steps_used, [39] zero fill
	output logic                   m_tuser    // [0] limit_hit
);

	seq_state_t          state_q, state_d;
	logic [XW-1:0]       x_q;
	logic [GW-1:0]       y1_q;
	logic [GW-1:0]       y2_q;
	logic [GW-1:0]       next_q;
	logic [GW-1:0]       cur_q;
	logic [GW-1:0]       diff_q;
	logic [STW-1:0]      steps_q;
	logic                hit_q;

	logic                mvalid_q;
	logic [ROOTW-1:0]    root_q;
	logic [STW-1:0]      ost_q;
	logic                ohit_q;

	div_ctl_t            div_ctl;
	div_stat_t           div_stat;
	logic [GW-1:0]       div_res;

	logic                in_beat;
	logic                in_zero;
	logic                out_load;
	logic                at_limit;
	logic [DIFFW+TOLW-1:0] prod;
	logic                conv;

	nsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.x      (x_q),
		.y      (cur_q),
		.stat   (div_stat),
		.res    (div_res)
	);

	// Convergence test on the registered difference
	always_comb begin
		prod     = (DIFFW + TOLW)'(diff_q[DIFFW-1:0]) * (DIFFW + TOLW)'(TOL_RECIP);
		conv     = (diff_q[GW-1:DIFFW] == '0) && (prod <= (DIFFW + TOLW)'(y2_q));
		at_limit = (steps_q >= STW'(MAX_ITER));
		in_zero  = (s_tdata[XW-1:0] == '0);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (s_tvalid) begin
					state_d = in_zero ? SQ_OUT : SQ_START;
				end
			end
			SQ_START: begin
				state_d = SQ_WAIT;
			end
			SQ_WAIT: begin
				if (div_stat.done) begin
					state_d = (steps_q == '0) ? SQ_START : SQ_DIFF;
				end
			end
			SQ_DIFF: begin
				state_d = SQ_CMP;
			end
			SQ_CMP: begin
				state_d = (conv || at_limit) ? SQ_OUT : SQ_START;
			end
			SQ_OUT: begin
				if (!mvalid_q || m_tready) begin
					state_d = SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	// Handshake and divider strobes
	always_comb begin
		s_tready      = (state_q == SQ_IDLE);
		in_beat       = s_tvalid && s_tready;
		div_ctl.start = (state_q == SQ_START);
		out_load      = (state_q == SQ_OUT) && (!mvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SQ_IDLE;
			mvalid_q <= 1'b0;
			steps_q  <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
			if (in_beat) begin
				steps_q <= '0;
			end else if (state_q == SQ_WAIT && div_stat.done) begin
				steps_q <= steps_q + STW'(1);
			end
		end
	end

	// Guess registers: load input and step results; shift or flag limit on a failed test
	always_ff @(posedge clk) begin
		if (in_beat) begin
			x_q    <= s_tdata[XW-1:0];
			y1_q   <= GUESS_ONE;
			cur_q  <= GUESS_ONE;
			next_q <= '0;
			hit_q  <= 1'b0;
		end
		if (state_q == SQ_WAIT && div_stat.done) begin
			if (steps_q == '0) begin
				y2_q  <= div_res;
				cur_q <= div_res;
			end else begin
				next_q <= div_res;
			end
		end
		if (state_q == SQ_DIFF) begin
			diff_q <= (y2_q > y1_q) ? (y2_q - y1_q) : (y1_q - y2_q);
		end
		if (state_q == SQ_CMP && !conv) begin
			if (at_limit) begin
				hit_q <= 1'b1;
			end else begin
				y1_q  <= y2_q;
				y2_q  <= next_q;
				cur_q <= next_q;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			root_q <= to_q16(next_q);
			ost_q  <= steps_q;
			ohit_q <= hit_q;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {{(OUT_DW - ROOTW - STW){1'b0}}, ost_q, root_q};
	assign m_tuser  = ohit_q;

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_steps_capped: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= STW'(MAX_ITER))
		else $error("step count beyond cap");

	a_limit_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(mvalid_q && ohit_q) |-> (ost_q == STW'(MAX_ITER)))
		else $error("limit flag without reaching the cap");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!mvalid_q || m_tready))
		else $error("output register overwritten");

endmodule

`default_nettype wire

// File: rtl/nsr_div.sv
// Bit-serial restoring divider that computes one Newton step (y + x/y) / 2.
`default_nettype none

module nsr_div import nsr_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire div_ctl_t        ctl,
	input  wire logic [XW-1:0]   x,
	input  wire logic [GW-1:0]   y,
	output div_stat_t            stat,
	output logic      [GW-1:0]   res
);

	div_state_t       state_q, state_d;
	logic [DCW-1:0]   cnt_q;
	logic [DVW-1:0]   dvd_q;
	logic [GW-1:0]    d_q;
	logic [GW-1:0]    y_q;
	logic [GW-1:0]    r_q;
	logic [GW-1:0]    q_q;
	logic             sat_q;

	logic [GW:0]      rr;
	logic [GW:0]      rr_sub;
	logic             ge;
	logic [GW-1:0]    r_next;
	logic [GW-1:0]    q_fin;
	logic [GW:0]      sum;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		rr     = {r_q, dvd_q[DVW-1]};
		rr_sub = rr - {1'b0, d_q};
		ge     = (rr >= {1'b0, d_q});
		r_next = ge ? rr_sub[GW-1:0] : rr[GW-1:0];
	end

	// Finish the step: saturate the quotient, add the guess, halve
	always_comb begin
		q_fin = sat_q ? '1 : q_q;
		sum   = {1'b0, y_q} + {1'b0, q_fin};
		res   = sum[GW:1];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DV_IDLE: begin
				if (ctl.start) begin
					state_d = DV_RUN;
				end
			end
			DV_RUN: begin
				if (cnt_q == '0) begin
					state_d = DV_FIN;
				end
			end
			DV_FIN: begin
				state_d = DV_IDLE;
			end
			default: begin
				state_d = DV_IDLE;
			end
		endcase
	end

	// Status outputs
	always_comb begin
		stat.busy = (state_q != DV_IDLE);
		stat.done = (state_q == DV_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Load operands, then advance one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && ctl.start) begin
			dvd_q <= {x, {(2 * FRAC_BITS){1'b0}}};
			d_q   <= (y == '0) ? GW'(1) : y;
			y_q   <= y;
			r_q   <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
			cnt_q <= DCW'(DVW - 1);
		end else if (state_q == DV_RUN) begin
			dvd_q <= {dvd_q[DVW-2:0], 1'b0};
			r_q   <= r_next;
			q_q   <= {q_q[GW-2:0], ge};
			sat_q <= sat_q | (ge && (cnt_q >= DCW'(GW)));
			cnt_q <= cnt_q - DCW'(1);
		end
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DV_RUN) |-> (r_q < d_q))
		else $error("partial remainder not below divisor");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DV_RUN) |-> (d_q != '0))
		else $error("divisor is zero during divide");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DV_FIN) |-> $past(state_q == DV_RUN))
		else $error("divide finished without running");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Stream testbench for the Newton square root block with a self-checking scoreboard.
`default_nettype none

module testbench;
	import nsr_pkg::*;

	// One result beat, unpacked from m_tdata and m_tuser
	typedef struct packed {
		logic [ROOTW-1:0] root;
		logic [STW-1:0]   steps_used;
		logic             limit_hit;
	} root_beat_t;

	// Predict the root for each accepted radicand and match result beats in order
	class sqrt_scoreboard;
		root_beat_t       expected_roots[$];
		logic [GW-1:0]    guess;
		logic [GW-1:0]    previous_guess;
		logic [STW-1:0]   step_count;
		int unsigned      errors;

		function new();
			guess          = '0;
			previous_guess = '0;
			step_count     = '0;
			errors         = 0;
		endfunction

		// One Newton update: (y + x/y) / 2 with a saturating 48-bit quotient
		function logic [GW-1:0] newton_update(logic [XW-1:0] x, logic [GW-1:0] y);
			logic [63:0] divisor;
			logic [63:0] quotient;
			logic [GW-1:0] q;
			logic [GW:0]   total;
			divisor  = (y == '0) ? 64'd1 : 64'(y);
			quotient = (64'(x) << (2 * FRAC_BITS)) / divisor;
			q        = ((quotient >> GW) != 0) ? '1 : quotient[GW-1:0];
			total    = {1'b0, y} + {1'b0, q};
			return total[GW:1];
		endfunction

		// Raw guess to Q16.16, clamp on overflow
		function logic [ROOTW-1:0] raw_to_q16(logic [GW-1:0] g);
			logic [63:0] v;
			if (FRAC_BITS >= 16) begin
				v = 64'(g) >> (FRAC_BITS - 16);
			end else begin
				v = 64'(g) << (16 - FRAC_BITS);
			end
			return (v > 64'hFFFF_FFFF) ? '1 : v[ROOTW-1:0];
		endfunction

		// Work out the expected beat for an accepted radicand
		function void note_radicand(logic [XW-1:0] x);
			root_beat_t    beat;
			logic [GW-1:0] y1;
			logic [GW-1:0] y2;
			logic [GW-1:0] nxt;
			logic [GW-1:0] diff;
			int unsigned   steps;
			logic          hit;
			if (x == '0) begin
				guess          = '0;
				previous_guess = '0;
				step_count     = '0;
				expected_roots.push_back('0);
				return;
			end
			y1    = GUESS_ONE;
			y2    = newton_update(x, y1);
			nxt   = newton_update(x, y2);
			steps = 2;
			hit   = 1'b0;
			while (1) begin
				diff = (y2 > y1) ? (y2 - y1) : (y1 - y2);
				if (diff <= y2 / GW'(TOL_RECIP)) begin
					break;
				end
				if (steps >= MAX_ITER) begin
					hit = 1'b1;
					break;
				end
				y1  = y2;
				y2  = nxt;
				nxt = newton_update(x, y2);
				steps++;
			end
			previous_guess  = y1;
			guess           = y2;
			step_count      = STW'(steps);
			beat.root       = raw_to_q16(nxt);
			beat.steps_used = STW'(steps);
			beat.limit_hit  = hit;
			expected_roots.push_back(beat);
		endfunction

		// Compare a result beat with the oldest expectation
		function void check_result(root_beat_t got);
			root_beat_t want;
			if (expected_roots.size() == 0) begin
				$error("unexpected result beat: root %0h steps_used %0d limit_hit %0b",
					got.root, got.steps_used, got.limit_hit);
				errors++;
				return;
			end
			want = expected_roots.pop_front();
			if (got.root !== want.root) begin
				$error("root: expected %0h actual %0h", want.root, got.root);
				errors++;
			end
			if (got.steps_used !== want.steps_used) begin
				$error("steps_used: expected %0d actual %0d", want.steps_used, got.steps_used);
				errors++;
			end
			if (got.limit_hit !== want.limit_hit) begin
				$error("limit_hit: expected %0b actual %0b", want.limit_hit, got.limit_hit);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_roots.size();
		endfunction
	endclass

	localparam int unsigned RANDOM_ITEMS   = 560;
	localparam int unsigned BURST_FIRST    = 100;  // sender offers back to back from here
	localparam int unsigned BURST_LAST     = 160;
	localparam int unsigned DRAIN_ITEM     = 400;  // sender waits for all results before this one
	localparam int unsigned HOLD_RESULT    = 150;  // receiver holds off before this result
	localparam int unsigned HOLD_CYCLES    = 6000;
	localparam int unsigned STEADY_FIRST   = 300;  // receiver takes every beat at once here
	localparam int unsigned STEADY_LAST    = 360;
	localparam int unsigned MAX_WAIT       = 13;
	localparam int unsigned DIRECTED_COUNT = 23;
	localparam logic [XW-1:0] RADICAND_MAX = '1;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_DW-1:0]  s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_DW-1:0] m_tdata;
	logic              m_tuser;

	sqrt_scoreboard sqrt_sb = new();

	newton_square_root u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// End a hung run
	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

	// Check every result beat as it is taken
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sqrt_sb.check_result({m_tdata[ROOTW-1:0], m_tdata[ROOTW+STW-1:ROOTW], m_tuser});
		end
	end

	// Offer a radicand beat after a random gap (none in a burst); hold until taken
	task automatic send_radicand(input logic [XW-1:0] x, input int unsigned idx);
		int unsigned gap;
		gap = (idx >= BURST_FIRST && idx < BURST_LAST) ? 0 : $urandom_range(0, MAX_WAIT);
		if (idx == DRAIN_ITEM && gap == 0) begin
			gap = 1;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			if (idx == DRAIN_ITEM) begin
				while (sqrt_sb.pending() != 0) @(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DW'(x);
		do @(posedge clk); while (!s_tready);
		sqrt_sb.note_radicand(x);
	endtask

	// Draw a radicand: zero, small, full range, random width, or near a perfect square
	function automatic logic [XW-1:0] random_radicand();
		int unsigned w;
		int unsigned r;
		logic [63:0] sq;
		if ($urandom_range(0, 19) == 0) begin
			return '0;
		end
		case ($urandom_range(0, 3))
			0: return XW'($urandom_range(1, 1000));
			1: return XW'($urandom());
			2: begin
				w = $urandom_range(1, XW);
				return XW'($urandom()) & ((XW'(1) << w) - XW'(1)) | (XW'(1) << (w - 1));
			end
			default: begin
				r  = $urandom_range(1, 46340);
				sq = 64'(r) * 64'(r) + 64'($urandom_range(0, 2)) - 64'd1;
				return XW'(sq);
			end
		endcase
	endfunction

	// Take result beats with random stalls, one long hold-off and one steady stretch
	initial begin
		int unsigned rx_count;
		int unsigned stall;
		rx_count = 0;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_count == HOLD_RESULT) begin
				stall = HOLD_CYCLES;
			end else if (rx_count >= STEADY_FIRST && rx_count < STEADY_LAST) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, MAX_WAIT);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			rx_count++;
		end
	end

	// Reset, directed radicands, random radicands, then drain and report
	initial begin
		logic [XW-1:0] directed [DIRECTED_COUNT];
		int unsigned idx;
		directed = '{
			'0, XW'(1), XW'(2), XW'(3), XW'(4), XW'(5), XW'(9), XW'(16),
			RADICAND_MAX, RADICAND_MAX - XW'(1),
			XW'(2147395600), XW'(2147395599),
			'0, '0,
			XW'(32'h4000_0000), XW'(32'h5555_5555), XW'(32'h2AAA_AAAA),
			XW'(65536), XW'(1000000), XW'(999999),
			XW'(32'h7FFF_0000), XW'(32'h0000_FFFF), XW'(1)
		};
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		idx = 0;
		foreach (directed[i]) begin
			send_radicand(directed[i], idx);
			idx++;
		end
		repeat (RANDOM_ITEMS) begin
			send_radicand(random_radicand(), idx);
			idx++;
		end
		s_tvalid <= 1'b0;
		while (sqrt_sb.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sqrt_sb.errors == 0 && sqrt_sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
rtl/nsr_pkg.sv
rtl/nsr_div.sv
rtl/newton_square_root.sv
bench/testbench.sv
